FILE: hw/rtl/hexmidi_pkg.sv
// ----------------------------------------------------------------------------
// hexmidi_pkg: shared types, codes and helpers of the hex text MIDI parser
// Parse state and event types, phase and event codes, character classes,
// and the number-field steps used by the per-character update.
// ----------------------------------------------------------------------------
package hexmidi_pkg;

  // parse phase codes
  localparam logic [2:0] PH_SKIP   = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_PREFIX = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  // event kinds
  localparam logic [1:0] EV_NOTE_ON      = 2'd0;
  localparam logic [1:0] EV_NOTE_OFF     = 2'd1;
  localparam logic [1:0] EV_SUSTAIN_ON   = 2'd2;
  localparam logic [1:0] EV_SUSTAIN_OFF  = 2'd3;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_UC  = 8'h58;
  localparam logic [7:0] CH_X_LC  = 8'h78;

  // MIDI values
  localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
  localparam logic [7:0] ST_NOTE_ON   = 8'h90;
  localparam logic [7:0] ST_CTRL      = 8'hB0;
  localparam logic [7:0] CC_SUSTAIN   = 8'h40;
  localparam logic [7:0] SUSTAIN_THR  = 8'd64;
  localparam logic [1:0] BYTES_NEEDED = 2'd3;

  typedef struct packed {
    logic [2:0]      phase;
    logic [1:0]      idx;
    logic [7:0]      acc;
    logic            neg;
    logic [2:0][7:0] bytes;
    logic            failed;
  } parse_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] note;
    logic [7:0] vel;
  } evt_t;

  // line length control from the step logic to the length counter
  typedef struct packed {
    logic inc;
    logic clr;
  } len_ctl_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF ||
           c == CH_LF || c == CH_CR;
  endfunction

  // close the pending number and store it
  function automatic parse_t finish_number(input parse_t s);
    parse_t     t;
    logic [7:0] v;
    t = s;
    v = s.neg ? 8'(8'd0 - s.acc) : s.acc;
    if (s.idx < BYTES_NEEDED) begin
      case (s.idx)
        2'd0:    t.bytes[0] = v;
        2'd1:    t.bytes[1] = v;
        default: t.bytes[2] = v;
      endcase
      t.idx = 2'(s.idx + 2'd1);
    end
    t.phase = (t.idx >= BYTES_NEEDED) ? PH_DONE : PH_SKIP;
    return t;
  endfunction

  // first character of a field
  function automatic parse_t start_field(input parse_t s, input logic [7:0] c);
    parse_t     t;
    logic [4:0] d;
    t = s;
    d = hex_value(c);
    if (!is_blank(c)) begin
      t.acc = 8'd0;
      t.neg = 1'b0;
      if (c == CH_PLUS) begin
        t.phase = PH_SIGN;
      end else if (c == CH_MINUS) begin
        t.neg   = 1'b1;
        t.phase = PH_SIGN;
      end else if (c == CH_ZERO) begin
        t.phase = PH_ZERO;
      end else if (d[4]) begin
        t.acc   = {4'd0, d[3:0]};
        t.phase = PH_DIGITS;
      end else if (c == CH_NUL) begin
        t.phase = PH_DONE;
      end else begin
        t.failed = 1'b1;
        t.phase  = PH_DONE;
      end
    end
    return t;
  endfunction

  function automatic parse_t end_and_restart(input parse_t s, input logic [7:0] c);
    parse_t t;
    t = finish_number(s);
    if (c == CH_NUL) t.phase = PH_DONE;
    else if (t.phase != PH_DONE) t = start_field(t, c);
    return t;
  endfunction

endpackage

FILE: hw/rtl/hexmidi_step.sv
// ----------------------------------------------------------------------------
// hexmidi_step: per-character update of the line parser
// Combinational: advances the parse state by one character and decides the
// event on newline.
// ----------------------------------------------------------------------------
module hexmidi_step (
  input  logic [7:0]            character,
  input  logic                  line_full,
  input  hexmidi_pkg::parse_t   cur,
  output hexmidi_pkg::parse_t   nxt,
  output hexmidi_pkg::len_ctl_t len_ctl,
  output logic                  emit,
  output hexmidi_pkg::evt_t     evt
);

  hexmidi_pkg::parse_t s;
  hexmidi_pkg::parse_t clr;
  logic [4:0]          d;
  logic [7:0]          st;
  logic [7:0]          d1;
  logic [7:0]          d2;
  logic                ok;

  always_comb begin
    clr        = cur;
    clr.phase  = hexmidi_pkg::PH_SKIP;
    clr.idx    = 2'd0;
    clr.acc    = 8'd0;
    clr.neg    = 1'b0;
    clr.failed = 1'b0;

    s           = cur;
    d           = hexmidi_pkg::hex_value(character);
    len_ctl     = '0;
    emit        = 1'b0;
    evt         = '0;
    ok          = 1'b0;
    st          = 8'd0;
    d1          = 8'd0;
    d2          = 8'd0;

    if (character == hexmidi_pkg::CH_CR) begin
      s = cur;
    end else if (character != hexmidi_pkg::CH_LF) begin
      if (line_full) begin
        // overlong line: drop it and this character
        s           = clr;
        len_ctl.clr = 1'b1;
      end else begin
        len_ctl.inc = 1'b1;
        case (cur.phase)
          hexmidi_pkg::PH_SIGN: begin
            if (character == hexmidi_pkg::CH_ZERO) begin
              s.phase = hexmidi_pkg::PH_ZERO;
            end else if (d[4]) begin
              s.acc   = {4'd0, d[3:0]};
              s.phase = hexmidi_pkg::PH_DIGITS;
            end else begin
              s.failed = 1'b1;
              s.phase  = hexmidi_pkg::PH_DONE;
            end
          end
          hexmidi_pkg::PH_ZERO: begin
            if (character == hexmidi_pkg::CH_X_LC || character == hexmidi_pkg::CH_X_UC) begin
              s.phase = hexmidi_pkg::PH_PREFIX;
            end else if (d[4]) begin
              s.acc   = {4'd0, d[3:0]};
              s.phase = hexmidi_pkg::PH_DIGITS;
            end else begin
              s = hexmidi_pkg::end_and_restart(cur, character);
            end
          end
          hexmidi_pkg::PH_PREFIX, hexmidi_pkg::PH_DIGITS: begin
            if (d[4]) begin
              s.acc   = {cur.acc[3:0], d[3:0]};
              s.phase = hexmidi_pkg::PH_DIGITS;
            end else begin
              s = hexmidi_pkg::end_and_restart(cur, character);
            end
          end
          hexmidi_pkg::PH_SKIP: begin
            s = hexmidi_pkg::start_field(cur, character);
          end
          default: begin
            s = cur;
          end
        endcase
      end
    end else begin
      // newline: close the pending number, decide, start a fresh line
      if (cur.phase inside {hexmidi_pkg::PH_ZERO, hexmidi_pkg::PH_PREFIX,
                            hexmidi_pkg::PH_DIGITS}) begin
        s = hexmidi_pkg::finish_number(cur);
      end else if (cur.phase == hexmidi_pkg::PH_SIGN) begin
        s.failed = 1'b1;
      end
      ok = !s.failed && (s.idx >= hexmidi_pkg::BYTES_NEEDED);
      st = s.bytes[0];
      d1 = s.bytes[1];
      d2 = s.bytes[2];
      len_ctl.clr = 1'b1;
      s.phase  = hexmidi_pkg::PH_SKIP;
      s.idx    = 2'd0;
      s.acc    = 8'd0;
      s.neg    = 1'b0;
      s.failed = 1'b0;
      if (ok) begin
        if (st == hexmidi_pkg::ST_NOTE_OFF ||
            (st == hexmidi_pkg::ST_NOTE_ON && d2 == 8'd0)) begin
          emit     = 1'b1;
          evt.kind = hexmidi_pkg::EV_NOTE_OFF;
          evt.note = d1;
        end else if (st == hexmidi_pkg::ST_NOTE_ON) begin
          emit     = 1'b1;
          evt.kind = hexmidi_pkg::EV_NOTE_ON;
          evt.note = d1;
          evt.vel  = d2;
        end else if (st == hexmidi_pkg::ST_CTRL && d1 == hexmidi_pkg::CC_SUSTAIN) begin
          emit     = 1'b1;
          evt.kind = (d2 >= hexmidi_pkg::SUSTAIN_THR) ? hexmidi_pkg::EV_SUSTAIN_ON
                                                      : hexmidi_pkg::EV_SUSTAIN_OFF;
        end
      end
    end
    nxt = s;
  end

endmodule

FILE: hw/rtl/hex_text_midi_line_parser_core.sv
// ----------------------------------------------------------------------------
// hex_text_midi_line_parser_core: hex text to MIDI event parser
// Turns lines like "90 3c 7f" into note on/off and sustain events.
// ----------------------------------------------------------------------------
// Takes one text character per beat and parses it on the fly; a newline
// closes the line and yields at most one event (note on, note off, sustain
// on/off) built from three hex bytes. Carriage returns are ignored and an
// overlong line (LINE_BUFFER_BYTES-1 kept characters, then one more) is
// discarded. Throughput is one character per clock while the input is not
// stalled: a character is captured in the input register, the parse state is
// updated from it, and an event lands in the output register at the same
// edge as that parse state update. The input stalls only while the output
// register holds an event that is stalled.
module hex_text_midi_line_parser_core #(
  parameter int LINE_BUFFER_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_character,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_kind,
  output logic [7:0] out_note_number,
  output logic [7:0] out_velocity
);

  localparam int LEN_W = $clog2(LINE_BUFFER_BYTES);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_BUFFER_BYTES - 1);

  // input register
  logic                  v1_r;
  logic [7:0]            ch1_r;

  // line and parse state
  logic [LEN_W-1:0]      len_r;
  logic [LEN_W-1:0]      len_nxt;
  hexmidi_pkg::parse_t   st_r;
  hexmidi_pkg::parse_t   st_nxt;

  // output register
  logic                  out_valid_r;
  hexmidi_pkg::evt_t     evt_r;

  hexmidi_pkg::len_ctl_t len_ctl;
  hexmidi_pkg::evt_t     evt;
  logic                  emit;
  logic                  blocked;
  logic                  proc;

  // a held event that cannot leave freezes the input stage
  assign blocked  = out_valid_r && out_stall;
  assign proc     = v1_r && !blocked;
  assign in_stall = v1_r && blocked;

  hexmidi_step u_step (
    .character (ch1_r),
    .line_full (len_r == LEN_MAX),
    .cur       (st_r),
    .nxt       (st_nxt),
    .len_ctl   (len_ctl),
    .emit      (emit),
    .evt       (evt)
  );

  always_comb begin
    len_nxt = len_r;
    if (len_ctl.clr) len_nxt = '0;
    else if (len_ctl.inc) len_nxt = LEN_W'(len_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (!in_stall) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      ch1_r <= in_character;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      st_r  <= '0;
    end else if (proc) begin
      len_r <= len_nxt;
      st_r  <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      evt_r <= evt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = evt_r.kind;
  assign out_note_number = evt_r.note;
  assign out_velocity    = evt_r.vel;

  // a newline always leaves an empty line and a fresh parse
  assert property (@(posedge clk) disable iff (!rst_n)
    (proc && ch1_r == hexmidi_pkg::CH_LF) |=>
      (len_r == '0 && st_r.phase == hexmidi_pkg::PH_SKIP && st_r.idx == 2'd0))
    else $error("line state not cleared after newline");

  // events only come from a processed newline
  assert property (@(posedge clk) disable iff (!rst_n)
    (proc && emit) |-> (ch1_r == hexmidi_pkg::CH_LF))
    else $error("event raised on a non-newline character");

  // kept line length never passes the buffer limit
  assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_MAX)
    else $error("line length out of range");

endmodule
